[hdl/pbsf_pkg.sv]
// ----------------------------------------------------------------------------
// pbsf_pkg
// Shared widths and types for the Pareto bound-set filter.
// ----------------------------------------------------------------------------
package pbsf_pkg;

   localparam int COST_W    = 32;  // one objective cost
   localparam int CSR_W     = 3;   // active objective count register
   localparam int ENTRIES_W = 5;   // entries_held result field

   typedef logic [COST_W-1:0]    cost_type;
   typedef logic [CSR_W-1:0]     csr_type;
   typedef logic [ENTRIES_W-1:0] entries_type;

endpackage

[hdl/pbsf_compare.sv]
// ----------------------------------------------------------------------------
// pbsf_compare
// Shared strict-dominance unit: all active objectives compared in parallel.
// ----------------------------------------------------------------------------
module pbsf_compare
   import pbsf_pkg::*;
#(
   parameter int MAX_OBJECTIVES = 4
) (
   input  cost_type [MAX_OBJECTIVES-1:0] stored_row,
   input  cost_type [MAX_OBJECTIVES-1:0] probe_row,
   input  logic     [MAX_OBJECTIVES-1:0] obj_mask,
   input  logic                          probe_beats,  // 1: probe must beat stored
   output logic                          beats
);

   always_comb begin
      beats = 1'b1;
      for (int i = 0; i < MAX_OBJECTIVES; i++) begin
         if (obj_mask[i]) begin
            if (probe_beats) begin
               if (!(probe_row[i] < stored_row[i])) beats = 1'b0;
            end else begin
               if (!(stored_row[i] < probe_row[i])) beats = 1'b0;
            end
         end
      end
   end

endmodule

[hdl/pbsf_store.sv]
// ----------------------------------------------------------------------------
// pbsf_store
// Cost vector memory: one row per slot, one write and one registered read.
// ----------------------------------------------------------------------------
module pbsf_store
   import pbsf_pkg::*;
#(
   parameter int SET_CAPACITY   = 16,
   parameter int MAX_OBJECTIVES = 4,
   localparam int SLOT_W = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic     [SLOT_W-1:0]         wr_addr,
   input  cost_type [MAX_OBJECTIVES-1:0] wr_data,
   input  logic     [SLOT_W-1:0]         rd_addr,
   output cost_type [MAX_OBJECTIVES-1:0] rd_data
);

   cost_type [MAX_OBJECTIVES-1:0] mem [SET_CAPACITY];
   cost_type [MAX_OBJECTIVES-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/pareto_bound_set_filter.sv]
// ----------------------------------------------------------------------------
// pareto_bound_set_filter
// Bounded set of cost vectors with strict-dominance check and insert.
// ----------------------------------------------------------------------------
// One request at a time. After a request is taken the block walks every slot
// of the set, one slot per cycle through a single shared compare unit fed by
// the memory's registered read port, then steps through the drain, write and
// done states; req_stall is high from accept until done hands the result to
// the output register. A finished result sits in an output register, so
// the next request is taken while the previous result still waits on
// rsp_stall. Check mode (mode 0) reports whether some valid stored vector is
// strictly below the input in every active objective. Insert mode (mode 1)
// drops every stored vector the input strictly beats, then writes the input
// into the lowest free slot or raises overflow when none is left. Ties in any
// active objective never count as dominance. csr_write_data sets the active
// objective count; zero acts as one, values above MAX_OBJECTIVES saturate.
// Write it only while idle. No clearing pass: slots carry valid bits.
// ----------------------------------------------------------------------------
module pareto_bound_set_filter
   import pbsf_pkg::*;
#(
   parameter int SET_CAPACITY   = 16,
   parameter int MAX_OBJECTIVES = 4
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  cost_type    req_cost_0,
   input  cost_type    req_cost_1,
   input  cost_type    req_cost_2,
   input  cost_type    req_cost_3,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_dominated,
   output logic        rsp_overflow,
   output entries_type rsp_entries_held,
   // configuration
   input  logic        csr_write_en,
   input  csr_type     csr_write_data
);

   localparam int SLOT_W  = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;
   localparam int COUNT_W = $clog2(SET_CAPACITY + 1);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SET_CAPACITY - 1);

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;  // issue one slot read per cycle
   localparam logic [2:0] ST_DRAIN = 3'd2;  // last compare in flight
   localparam logic [2:0] ST_WRITE = 3'd3;  // store vector or flag overflow
   localparam logic [2:0] ST_DONE  = 3'd4;  // hand result to output register

   logic [2:0] state_ff, state_in;

   // request context
   logic                          mode_ff;
   cost_type [MAX_OBJECTIVES-1:0] vec_ff;
   logic     [MAX_OBJECTIVES-1:0] obj_mask_ff, obj_mask_in;
   csr_type                       objectives_ff;
   csr_type                       used_obj;
   cost_type [3:0]                req_costs;

   // scan and compare pipeline
   logic [SLOT_W-1:0] scan_ff;
   logic              cmp_valid_ff;
   logic [SLOT_W-1:0] cmp_slot_ff;
   logic              dom_ff;
   logic              found_ff;
   logic [SLOT_W-1:0] free_ff;
   logic              overflow_ff;

   // set state
   logic [SET_CAPACITY-1:0] entry_valid_ff, entry_valid_in;
   logic [COUNT_W-1:0]      entry_count_ff, entry_count_in;

   // result register
   logic        rsp_valid_ff;
   logic        rsp_dominated_ff;
   logic        rsp_overflow_ff;
   entries_type rsp_entries_ff;

   cost_type [MAX_OBJECTIVES-1:0] rd_data;
   logic beats;
   logic hit;
   logic kill;
   logic store_wr;
   logic req_accept;
   logic rsp_free;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   assign req_costs = {req_cost_3, req_cost_2, req_cost_1, req_cost_0};

   // clamp the objective count to 1..MAX_OBJECTIVES, then build the mask
   always_comb begin
      used_obj = objectives_ff;
      if (objectives_ff == '0) begin
         used_obj = CSR_W'(1);
      end else if (objectives_ff > CSR_W'(MAX_OBJECTIVES)) begin
         used_obj = CSR_W'(MAX_OBJECTIVES);
      end
      for (int i = 0; i < MAX_OBJECTIVES; i++) begin
         obj_mask_in[i] = (CSR_W'(i) < used_obj);
      end
   end

   pbsf_store #(
      .SET_CAPACITY   (SET_CAPACITY),
      .MAX_OBJECTIVES (MAX_OBJECTIVES)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_wr),
      .wr_addr (free_ff),
      .wr_data (vec_ff),
      .rd_addr (scan_ff),
      .rd_data (rd_data)
   );

   // check: stored vs probe; insert: probe vs stored
   pbsf_compare #(
      .MAX_OBJECTIVES (MAX_OBJECTIVES)
   ) u_compare (
      .stored_row  (rd_data),
      .probe_row   (vec_ff),
      .obj_mask    (obj_mask_ff),
      .probe_beats (mode_ff),
      .beats       (beats)
   );

   // only valid slots count; stale memory contents are masked here
   assign hit      = cmp_valid_ff && entry_valid_ff[cmp_slot_ff] && beats;
   assign kill     = hit && mode_ff;
   assign store_wr = (state_ff == ST_WRITE) && mode_ff && found_ff;

   always_comb begin
      entry_valid_in = entry_valid_ff;
      entry_count_in = entry_count_ff;
      if (kill) begin
         entry_valid_in[cmp_slot_ff] = 1'b0;
         entry_count_in = entry_count_ff - COUNT_W'(1);
      end
      if (store_wr) begin
         entry_valid_in[free_ff] = 1'b1;
         entry_count_in = entry_count_ff + COUNT_W'(1);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_accept) state_in = ST_SCAN;
         ST_SCAN:  if (scan_ff == LAST_SLOT) state_in = ST_DRAIN;
         ST_DRAIN: state_in = ST_WRITE;
         ST_WRITE: state_in = ST_DONE;
         ST_DONE:  if (rsp_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         objectives_ff  <= CSR_W'(4);
         entry_valid_ff <= '0;
         entry_count_ff <= '0;
         cmp_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_valid_ff <= entry_valid_in;
         entry_count_ff <= entry_count_in;
         cmp_valid_ff   <= (state_ff == ST_SCAN);
         if (csr_write_en) begin
            objectives_ff <= csr_write_data;
         end
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == ST_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end
      end
   end

   // datapath, no reset needed
   always_ff @(posedge clock) begin
      cmp_slot_ff <= scan_ff;
      if (req_accept) begin
         mode_ff     <= req_mode;
         obj_mask_ff <= obj_mask_in;
         for (int i = 0; i < MAX_OBJECTIVES; i++) begin
            vec_ff[i] <= req_costs[i];
         end
         scan_ff  <= '0;
         dom_ff   <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         if (state_ff == ST_SCAN && scan_ff != LAST_SLOT) begin
            scan_ff <= scan_ff + SLOT_W'(1);
         end
         if (hit && !mode_ff) begin
            dom_ff <= 1'b1;
         end
         // slots retire in order, so the first one left empty is the lowest
         if (cmp_valid_ff && !found_ff && !(entry_valid_ff[cmp_slot_ff] && !kill)) begin
            found_ff <= 1'b1;
            free_ff  <= cmp_slot_ff;
         end
      end
      if (state_ff == ST_WRITE) begin
         overflow_ff <= mode_ff && !found_ff;
      end
      if (state_ff == ST_DONE && rsp_free) begin
         rsp_dominated_ff <= dom_ff;
         rsp_overflow_ff  <= overflow_ff;
         rsp_entries_ff   <= ENTRIES_W'(entry_count_ff);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_dominated    = rsp_dominated_ff;
   assign rsp_overflow     = rsp_overflow_ff;
   assign rsp_entries_held = rsp_entries_ff;

   // fill count tracks the valid bits whenever the sequencer is at rest
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> entry_count_ff == COUNT_W'($countones(entry_valid_ff)))
      else $error("entry count out of step with valid bits");

   // an accepted request always starts a scan
   a_accept_scans: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == ST_SCAN)
      else $error("accepted request did not start a scan");

   // overflow only when every slot is still occupied after pruning
   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE && mode_ff && !found_ff) |-> &entry_valid_ff)
      else $error("overflow with a free slot");

endmodule
